### rtl/gbvw_pkg.sv
// Shared types and constants for the Gaussian beam volume weighting block.
`timescale 1ns / 1ps
package gbvw_pkg;

  localparam int SAMPLE_BITS      = 32;
  localparam int WEIGHT_FRAC_BITS = 24;

  localparam int CFG_W     = 25;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PEAK     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAIST    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAYLEIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RSTEP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ASTEP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TSAMP    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RPTS     = 3'd7;

  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW    = 2;

  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 33;
  localparam int DIV_CNT_W = 6;

  // exp(-1) in Q32 as the truncated 12-term series yields it
  localparam logic [30:0] E1_Q32 = 31'd1580030169;

  typedef struct packed {
    logic [23:0]        peak;
    logic [19:0]        waist;
    logic [23:0]        rayleigh;
    logic [19:0]        rstep;
    logic [19:0]        astep;
    logic signed [24:0] origin;
    logic [15:0]        tsamp;
    logic [11:0]        rpts;
  } cfg_t;

  typedef struct packed {
    logic [31:0] sample;
    logic        need_w;
    logic [11:0] ridx;
    logic [15:0] zidx;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t head;
  } fq_status_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

### rtl/gbvw_front.sv
// Front end: index tracking, pair classification and the job queue.
`timescale 1ns / 1ps
module gbvw_front import gbvw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic signed [31:0] in_sample,
  input  logic               in_volume_start,
  input  logic               in_push,
  output logic               in_full,
  output fq_status_t         fq,
  input  logic               fq_pop
);

  logic [15:0] t_idx_r, t_idx_nxt;
  logic [11:0] r_idx_r, r_idx_nxt;
  logic [15:0] z_idx_r, z_idx_nxt;
  logic [15:0] t_cur, t_inc, nt;
  logic [11:0] r_cur, r_inc, nr;
  logic [15:0] z_cur;
  logic        accept;

  job_t             mem_r [FQ_DEPTH];
  logic [FQ_AW-1:0] wp_r, rp_r;
  logic [FQ_AW:0]   cnt_r, cnt_nxt;

  assign in_full = (cnt_r == (FQ_AW+1)'(FQ_DEPTH));
  assign accept  = in_push && !in_full;

  always_comb begin
    t_cur = in_volume_start ? 16'd0 : t_idx_r;
    r_cur = in_volume_start ? 12'd0 : r_idx_r;
    z_cur = in_volume_start ? 16'd0 : z_idx_r;
    nt    = (cfg.tsamp == 16'd0) ? 16'd1 : cfg.tsamp;
    nr    = (cfg.rpts == 12'd0) ? 12'd1 : cfg.rpts;
    t_inc = t_cur + 16'd1;
    r_inc = r_cur + 12'd1;
    t_idx_nxt = t_inc;
    r_idx_nxt = r_cur;
    z_idx_nxt = z_cur;
    if (t_inc == 16'd0 || t_inc >= nt) begin
      t_idx_nxt = 16'd0;
      if (r_inc == 12'd0 || r_inc >= nr) begin
        r_idx_nxt = 12'd0;
        z_idx_nxt = z_cur + 16'd1;
      end else begin
        r_idx_nxt = r_inc;
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept && !fq_pop) cnt_nxt = cnt_r + (FQ_AW+1)'(1);
    else if (!accept && fq_pop) cnt_nxt = cnt_r - (FQ_AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_idx_r <= '0;
      r_idx_r <= '0;
      z_idx_r <= '0;
      wp_r    <= '0;
      rp_r    <= '0;
      cnt_r   <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept) begin
        t_idx_r <= t_idx_nxt;
        r_idx_r <= r_idx_nxt;
        z_idx_r <= z_idx_nxt;
        wp_r    <= wp_r + FQ_AW'(1);
      end
      if (fq_pop) rp_r <= rp_r + FQ_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_r[wp_r].sample <= in_sample;
      mem_r[wp_r].need_w <= (t_cur == 16'd0);
      mem_r[wp_r].ridx   <= r_cur;
      mem_r[wp_r].zidx   <= z_cur;
    end
  end

  assign fq.valid = (cnt_r != '0);
  assign fq.head  = mem_r[rp_r];

endmodule

### rtl/gbvw_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module gbvw_div import gbvw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_NUM_W-1:0] num_r, num_nxt;
  logic [DIV_DEN_W:0]   rem_r, rem_nxt, rem_sh;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r, done_r;
  logic                 qb;

  always_comb begin
    rem_sh  = {rem_r[DIV_DEN_W-1:0], num_r[DIV_NUM_W-1]};
    qb      = (rem_sh >= {1'b0, den_r});
    rem_nxt = qb ? rem_sh - {1'b0, den_r} : rem_sh;
    num_nxt = {num_r[DIV_NUM_W-2:0], qb};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '1;
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = num_r;

endmodule

### rtl/gbvw_weight.sv
// Beam weight sequencer: fluence of one radius/depth pair.
`timescale 1ns / 1ps
module gbvw_weight import gbvw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        start,
  input  logic [11:0] ridx,
  input  logic [15:0] zidx,
  output logic        done,
  output logic [31:0] weight
);

  localparam logic [4:0] W_IDLE  = 5'd0;
  localparam logic [4:0] W_ABS   = 5'd1;
  localparam logic [4:0] W_NORM  = 5'd2;
  localparam logic [4:0] W_SQ    = 5'd3;
  localparam logic [4:0] W_GDIV  = 5'd4;
  localparam logic [4:0] W_GWAIT = 5'd5;
  localparam logic [4:0] W_RDIV  = 5'd6;
  localparam logic [4:0] W_RWAIT = 5'd7;
  localparam logic [4:0] W_U2    = 5'd8;
  localparam logic [4:0] W_X     = 5'd9;
  localparam logic [4:0] W_EXP   = 5'd10;
  localparam logic [4:0] W_TM    = 5'd11;
  localparam logic [4:0] W_TD    = 5'd12;
  localparam logic [4:0] W_TWAIT = 5'd13;
  localparam logic [4:0] W_EPOW  = 5'd14;
  localparam logic [4:0] W_P     = 5'd15;
  localparam logic [4:0] W_W     = 5'd16;

  localparam int SH = 54 - WEIGHT_FRAC_BITS;

  logic [4:0]         state_r;
  logic signed [37:0] z_r;
  logic [37:0]        a_r, b_r;
  logic [31:0]        bsq_r;
  logic [32:0]        den_r;
  logic [30:0]        g_r;
  logic [11:0]        ridx_r;
  logic [23:0]        u_r;
  logic [31:0]        u2_r;
  logic [33:0]        x_r;
  logic [15:0]        f_r;
  logic [4:0]         n_r;
  logic [32:0]        term_r;
  logic [33:0]        sum_r;
  logic [32:0]        tp_r;
  logic [3:0]         k_r;
  logic [38:0]        p_r;
  logic [31:0]        weight_r;
  logic               done_r;

  logic [35:0] zprod;
  logic [31:0] a2, b2, rprod;
  logic [47:0] u2full;
  logic [62:0] xprod;
  logic [48:0] tprod;
  logic [64:0] eprod;
  logic [54:0] pprod;
  logic [64:0] wprod;
  logic [65:0] wrnd, wq;
  logic [32:0] term_new;
  logic [19:0] w0;
  logic [23:0] zr;

  div_req_t div_req;
  div_rsp_t div_rsp;

  gbvw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    w0       = (cfg.waist == 20'd0) ? 20'd1 : cfg.waist;
    zr       = (cfg.rayleigh == 24'd0) ? 24'd1 : cfg.rayleigh;
    zprod    = 36'(zidx) * 36'(cfg.astep);
    a2       = 32'(a_r[15:0]) * 32'(a_r[15:0]);
    b2       = 32'(b_r[15:0]) * 32'(b_r[15:0]);
    rprod    = 32'(ridx_r) * 32'(cfg.rstep);
    u2full   = 48'(u_r) * 48'(u_r);
    xprod    = 63'(u2_r) * 63'(g_r);
    tprod    = 49'(term_r) * 49'(f_r);
    eprod    = 65'(sum_r) * 65'(E1_Q32);
    pprod    = 55'(cfg.peak) * 55'(g_r);
    wprod    = 65'(p_r) * 65'(sum_r[33:8]);
    wrnd     = {1'b0, wprod} + (66'd1 << (SH - 1));
    wq       = wrnd >> SH;
    term_new = div_rsp.quo[32:0];
  end

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    unique case (state_r)
      W_GDIV: begin
        div_req.start = 1'b1;
        div_req.num   = {2'b00, bsq_r, 30'd0};
        div_req.den   = den_r;
      end
      W_RDIV: begin
        div_req.start = 1'b1;
        div_req.num   = {16'd0, rprod, 16'd0};
        div_req.den   = 33'(w0);
      end
      W_TD: begin
        div_req.start = 1'b1;
        div_req.num   = 64'(tp_r);
        div_req.den   = 33'(k_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= W_IDLE;
      weight_r <= '0;
      done_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        W_IDLE: if (start) begin
          z_r     <= $signed({2'b00, zprod}) + 38'(cfg.origin);
          ridx_r  <= ridx;
          state_r <= W_ABS;
        end
        W_ABS: begin
          a_r     <= z_r[37] ? 38'(-z_r) : 38'(z_r);
          b_r     <= 38'(zr);
          state_r <= W_NORM;
        end
        W_NORM: begin
          if (a_r[37:16] != '0 || b_r[37:16] != '0) begin
            a_r <= a_r >> 1;
            b_r <= b_r >> 1;
          end else begin
            state_r <= W_SQ;
          end
        end
        W_SQ: begin
          bsq_r   <= b2;
          den_r   <= {1'b0, a2} + {1'b0, b2};
          state_r <= W_GDIV;
        end
        W_GDIV: state_r <= W_GWAIT;
        W_GWAIT: if (div_rsp.done) begin
          g_r     <= div_rsp.quo[30:0];
          state_r <= W_RDIV;
        end
        W_RDIV: state_r <= W_RWAIT;
        W_RWAIT: if (div_rsp.done) begin
          u_r     <= (div_rsp.quo > 64'hFFFFFF) ? 24'hFFFFFF : div_rsp.quo[23:0];
          state_r <= W_U2;
        end
        W_U2: begin
          u2_r    <= u2full[47:16];
          state_r <= W_X;
        end
        W_X: begin
          x_r     <= xprod[62:29];
          state_r <= W_EXP;
        end
        W_EXP: begin
          if (x_r[33:21] != '0) begin
            sum_r   <= '0;
            state_r <= W_P;
          end else begin
            f_r     <= x_r[15:0];
            n_r     <= x_r[20:16];
            term_r  <= 33'h1_0000_0000;
            sum_r   <= 34'h1_0000_0000;
            k_r     <= 4'd1;
            state_r <= W_TM;
          end
        end
        W_TM: begin
          tp_r    <= tprod[48:16];
          state_r <= W_TD;
        end
        W_TD: state_r <= W_TWAIT;
        W_TWAIT: if (div_rsp.done) begin
          term_r <= term_new;
          if (k_r[0]) begin
            sum_r <= (34'(term_new) > sum_r) ? 34'd0 : sum_r - 34'(term_new);
          end else begin
            sum_r <= sum_r + 34'(term_new);
          end
          k_r     <= k_r + 4'd1;
          state_r <= (k_r == 4'd12) ? W_EPOW : W_TM;
        end
        W_EPOW: begin
          if (n_r != '0) begin
            sum_r <= 34'(eprod[64:32]);
            n_r   <= n_r - 5'd1;
          end else begin
            state_r <= W_P;
          end
        end
        W_P: begin
          p_r     <= pprod[54:16];
          state_r <= W_W;
        end
        W_W: begin
          weight_r <= (wq[65:32] != '0) ? 32'hFFFF_FFFF : wq[31:0];
          done_r   <= 1'b1;
          state_r  <= W_IDLE;
        end
        default: state_r <= W_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign weight = weight_r;

endmodule

### rtl/gbvw_back.sv
// Back end: weight update, sample scaling, rounding, saturation, result queue.
`timescale 1ns / 1ps
module gbvw_back import gbvw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  fq_status_t         fq,
  output logic               fq_pop,
  output logic               busy,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_weighted_sample
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_WGT  = 2'd1;
  localparam logic [1:0] B_MUL  = 2'd2;
  localparam logic [1:0] B_OUT  = 2'd3;

  localparam logic [31:0] MAXV = 32'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic [64:0] MAXQ = 65'(MAXV);

  logic [1:0]  state_r, state_nxt;
  job_t        job_r;
  logic [63:0] prod_r;
  logic        neg_r;

  logic signed [SAMPLE_BITS-1:0] raw;
  logic signed [32:0]            ext, mag33;
  logic [64:0]                   rnd, q;
  logic [31:0]                   res;
  logic                          w_start, w_done, push, out_pop_ok;
  logic [31:0]                   weight;

  logic [31:0] oq_mem_r [2];
  logic        oq_wp_r, oq_rp_r;
  logic [1:0]  oq_cnt_r, oq_cnt_nxt;

  gbvw_weight u_weight (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .start  (w_start),
    .ridx   (fq.head.ridx),
    .zidx   (fq.head.zidx),
    .done   (w_done),
    .weight (weight)
  );

  always_comb begin
    state_nxt = state_r;
    fq_pop    = 1'b0;
    w_start   = 1'b0;
    push      = 1'b0;
    unique case (state_r)
      B_IDLE: if (fq.valid && oq_cnt_r != 2'd2) begin
        fq_pop    = 1'b1;
        w_start   = fq.head.need_w;
        state_nxt = fq.head.need_w ? B_WGT : B_MUL;
      end
      B_WGT: if (w_done) state_nxt = B_MUL;
      B_MUL: state_nxt = B_OUT;
      B_OUT: begin
        push      = 1'b1;
        state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    raw   = job_r.sample[SAMPLE_BITS-1:0];
    ext   = 33'(raw);
    mag33 = ext[32] ? -ext : ext;
    rnd   = {1'b0, prod_r} + (65'd1 << (WEIGHT_FRAC_BITS - 1));
    q     = rnd >> WEIGHT_FRAC_BITS;
    if (neg_r) begin
      res = (q > MAXQ + 65'd1) ? ~MAXV : -q[31:0];
    end else begin
      res = (q > MAXQ) ? MAXV : q[31:0];
    end
  end

  assign out_pop_ok = out_pop && (oq_cnt_r != 2'd0);

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (push && !out_pop_ok) oq_cnt_nxt = oq_cnt_r + 2'd1;
    else if (!push && out_pop_ok) oq_cnt_nxt = oq_cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      oq_wp_r  <= 1'b0;
      oq_rp_r  <= 1'b0;
      oq_cnt_r <= '0;
    end else begin
      state_r  <= state_nxt;
      oq_cnt_r <= oq_cnt_nxt;
      if (push) oq_wp_r <= ~oq_wp_r;
      if (out_pop_ok) oq_rp_r <= ~oq_rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fq_pop) job_r <= fq.head;
    if (state_r == B_MUL) begin
      prod_r <= 64'(mag33[31:0]) * 64'(weight);
      neg_r  <= ext[32];
    end
    if (push) oq_mem_r[oq_wp_r] <= res;
  end

  assign busy                = (state_r != B_IDLE);
  assign out_empty           = (oq_cnt_r == 2'd0);
  assign out_weighted_sample = oq_mem_r[oq_rp_r];

endmodule

### rtl/gaussian_beam_volume_weighting.sv
// Top level: configuration registers, front end and back end of the beam weighting block.
// Each accepted word passes through the job queue, then the back-end states MUL and OUT, into the result queue.
// The first sample of each radius/depth pair also waits for the weight sequencer, whose
// two divisions and twelve series steps all use the one shared divider.
// The back end handles one word at a time and pops the next only in idle with room in the result queue.
// Reset (synchronous, active low) loads register defaults, clears indices and both queues.
`timescale 1ns / 1ps
module gaussian_beam_volume_weighting import gbvw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic signed [31:0]   in_sample,
  input  logic                 in_volume_start,
  input  logic                 in_push,
  output logic                 in_full,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic signed [31:0]   out_weighted_sample,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t       cfg_r;
  fq_status_t fq;
  logic       fq_pop;
  logic       back_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.peak     <= 24'd65536;
      cfg_r.waist    <= 20'd1000;
      cfg_r.rayleigh <= 24'd5000;
      cfg_r.rstep    <= 20'd1000;
      cfg_r.astep    <= 20'd1000;
      cfg_r.origin   <= '0;
      cfg_r.tsamp    <= 16'd1024;
      cfg_r.rpts     <= 12'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PEAK:     cfg_r.peak     <= cfg_data[23:0];
        REG_WAIST:    cfg_r.waist    <= cfg_data[19:0];
        REG_RAYLEIGH: cfg_r.rayleigh <= cfg_data[23:0];
        REG_RSTEP:    cfg_r.rstep    <= cfg_data[19:0];
        REG_ASTEP:    cfg_r.astep    <= cfg_data[19:0];
        REG_ORIGIN:   cfg_r.origin   <= $signed(cfg_data[24:0]);
        REG_TSAMP:    cfg_r.tsamp    <= cfg_data[15:0];
        REG_RPTS:     cfg_r.rpts     <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  gbvw_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_sample       (in_sample),
    .in_volume_start (in_volume_start),
    .in_push         (in_push),
    .in_full         (in_full),
    .fq              (fq),
    .fq_pop          (fq_pop)
  );

  gbvw_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .fq                  (fq),
    .fq_pop              (fq_pop),
    .busy                (back_busy),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_weighted_sample (out_weighted_sample)
  );

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (out_empty && !fq.valid && !back_busy) |=> out_empty)
    else $error("result appeared with no word in flight");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fq_pop |-> fq.valid)
    else $error("job queue popped while empty");

endmodule

### tb/sv/tb_gaussian_beam_volume_weighting.sv
// Testbench for the Gaussian beam volume weighting block: directed and random words checked
// against a cycle-free fixed-point model of the beam weight and sample scaling.
`timescale 1ns / 1ps
module tb_gaussian_beam_volume_weighting;
  import gbvw_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic signed [31:0]   in_sample = '0;
  logic                 in_volume_start = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic signed [31:0]   out_weighted_sample;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  gaussian_beam_volume_weighting i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_sample           (in_sample),
    .in_volume_start     (in_volume_start),
    .in_push             (in_push),
    .in_full             (in_full),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_weighted_sample (out_weighted_sample),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #5 clk = ~clk;

  cfg_t        beam_cfg;
  logic [15:0] time_idx;
  logic [11:0] radial_idx;
  logic [15:0] axial_idx;
  logic [31:0] pair_weight;

  logic [31:0] expected_words[$];
  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          pop_stall_pct = 0;
  int          pop_hold_left = 0;

  function automatic logic [63:0] series_exp(logic [63:0] f);
    logic [63:0] term;
    logic [63:0] sum;
    term = 64'd1 << 32;
    sum = term;
    for (int k = 1; k <= 12; k++) begin
      term = (term * f) / (64'(k) << 16);
      if (k % 2 == 1) begin
        sum = (term > sum) ? 64'd0 : sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] neg_exp(logic [63:0] x);
    logic [63:0] v;
    logic [63:0] e1;
    logic [63:0] n;
    if (x >= (64'd32 << 16)) return 64'd0;
    n = x >> 16;
    v = series_exp(x & 64'hFFFF);
    e1 = series_exp(64'd65536);
    for (longint i = 0; i < n; i++) v = (v * e1) >> 32;
    return v;
  endfunction

  function automatic logic [31:0] fluence_weight();
    logic [63:0] w0, zr, a, b, m, g, r, u, u2, x, e, p, w;
    longint      z;
    int          s, sh;
    w0 = (beam_cfg.waist == 0) ? 64'd1 : 64'(beam_cfg.waist);
    zr = (beam_cfg.rayleigh == 0) ? 64'd1 : 64'(beam_cfg.rayleigh);
    z = longint'(beam_cfg.origin) + longint'(64'(axial_idx) * 64'(beam_cfg.astep));
    a = (z < 0) ? 64'(-z) : 64'(z);
    b = zr;
    m = (a > b) ? a : b;
    s = 0;
    while ((m >> s) >= 64'd65536) s++;
    a = a >> s;
    b = b >> s;
    g = ((b * b) << 30) / (a * a + b * b);
    r = 64'(radial_idx) * 64'(beam_cfg.rstep);
    u = (r << 16) / w0;
    if (u > 64'hFFFFFF) u = 64'hFFFFFF;
    u2 = (u * u) >> 16;
    x = (64'd2 * u2 * g) >> 30;
    e = neg_exp(x);
    p = (64'(beam_cfg.peak) * g) >> 16;
    sh = 54 - WEIGHT_FRAC_BITS;
    w = (p * (e >> 8) + (64'd1 << (sh - 1))) >> sh;
    if (w > 64'hFFFFFFFF) w = 64'hFFFFFFFF;
    return w[31:0];
  endfunction

  function automatic logic [31:0] weigh_sample(logic [31:0] raw, logic vstart);
    longint      smp, res;
    logic [63:0] mag, q;
    logic [15:0] nt;
    logic [11:0] nr;
    smp = longint'($signed(raw));
    if (vstart) begin
      time_idx = '0;
      radial_idx = '0;
      axial_idx = '0;
    end
    if (time_idx == 0) pair_weight = fluence_weight();
    mag = (smp < 0) ? 64'(-smp) : 64'(smp);
    q = (mag * 64'(pair_weight) + (64'd1 << (WEIGHT_FRAC_BITS - 1))) >> WEIGHT_FRAC_BITS;
    if (smp < 0) begin
      res = (q > 64'h80000000) ? -longint'(64'h80000000) : -longint'(q);
    end else begin
      res = (q > 64'h7FFFFFFF) ? longint'(64'h7FFFFFFF) : longint'(q);
    end
    nt = (beam_cfg.tsamp == 0) ? 16'd1 : beam_cfg.tsamp;
    nr = (beam_cfg.rpts == 0) ? 12'd1 : beam_cfg.rpts;
    time_idx = time_idx + 16'd1;
    if (time_idx == 0 || time_idx >= nt) begin
      time_idx = '0;
      radial_idx = radial_idx + 12'd1;
      if (radial_idx == 0 || radial_idx >= nr) begin
        radial_idx = '0;
        axial_idx = axial_idx + 16'd1;
      end
    end
    return res[31:0];
  endfunction

  task automatic send_word(logic [31:0] smp, logic vstart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_sample <= smp;
    in_volume_start <= vstart;
    do @(posedge clk); while (in_full);
    expected_words.push_back(weigh_sample(smp, vstart));
  endtask

  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_PEAK:     beam_cfg.peak = val[23:0];
      REG_WAIST:    beam_cfg.waist = val[19:0];
      REG_RAYLEIGH: beam_cfg.rayleigh = val[23:0];
      REG_RSTEP:    beam_cfg.rstep = val[19:0];
      REG_ASTEP:    beam_cfg.astep = val[19:0];
      REG_ORIGIN:   beam_cfg.origin = val[24:0];
      REG_TSAMP:    beam_cfg.tsamp = val[15:0];
      REG_RPTS:     beam_cfg.rpts = val[11:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick(int unsigned lo, int unsigned hi);
    int unsigned c;
    c = $urandom_range(7);
    if (c == 0) return lo;
    if (c == 1) return hi;
    return $urandom_range(hi, lo);
  endfunction

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'($urandom_range(255)) - 32'd128;
      default: return $urandom;
    endcase
  endfunction

  task automatic load_random_beam();
    write_reg(REG_PEAK, ($urandom_range(3) == 0) ? pick(0, 24'hFFFFFF) : pick(0, 24'h3FFFF));
    write_reg(REG_WAIST, pick(0, 20'hFFFFF));
    write_reg(REG_RAYLEIGH, pick(0, 24'hFFFFFF));
    write_reg(REG_RSTEP, pick(0, 20'hFFFFF));
    write_reg(REG_ASTEP, pick(0, 20'hFFFFF));
    write_reg(REG_ORIGIN, pick(0, 25'h1FFFFFF));
    write_reg(REG_TSAMP, ($urandom_range(15) == 0) ? pick(0, 16'hFFFF) : pick(0, 16));
    write_reg(REG_RPTS, ($urandom_range(15) == 0) ? pick(0, 12'hFFF) : pick(0, 5));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (expected_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected word %h", out_weighted_sample);
      end else begin
        if (out_weighted_sample !== expected_words[0]) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("weighted_sample mismatch: expected %h actual %h",
                     expected_words[0], out_weighted_sample);
        end
        void'(expected_words.pop_front());
      end
    end
    if (pop_hold_left > 0) begin
      pop_hold_left = pop_hold_left - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  task automatic test_reset_defaults();
    send_word(32'h7FFFFFFF, 1'b1);
    send_word(32'h80000000, 1'b0);
    send_word(32'h00000000, 1'b0);
    send_word(32'hFFFFFFFF, 1'b0);
    send_word(32'h00000001, 1'b0);
    drain();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_TSAMP, 16'd1);
    write_reg(REG_RPTS, 12'd2);
    write_reg(REG_PEAK, 24'hFFFFFF);
    send_word(32'h7FFFFFFF, 1'b1);
    send_word(32'h80000000, 1'b0);
    drain();
    write_reg(REG_WAIST, 20'd0);
    write_reg(REG_RAYLEIGH, 24'd0);
    write_reg(REG_RSTEP, 20'hFFFFF);
    write_reg(REG_ORIGIN, 25'h1000000);
    send_word(32'h12345678, 1'b1);
    send_word(32'hEDCBA987, 1'b0);
    send_word(32'h40000000, 1'b0);
    drain();
    write_reg(REG_ORIGIN, 25'h0FFFFFF);
    write_reg(REG_ASTEP, 20'hFFFFF);
    write_reg(REG_RAYLEIGH, 24'hFFFFFF);
    write_reg(REG_WAIST, 20'hFFFFF);
    write_reg(REG_TSAMP, 16'd0);
    write_reg(REG_RPTS, 12'd0);
    send_word(32'h55555555, 1'b0);
    send_word(32'hAAAAAAAA, 1'b1);
    send_word(32'h00FF00FF, 1'b0);
    drain();
    write_reg(REG_PEAK, 24'd0);
    send_word(32'h7FFFFFFF, 1'b0);
    drain();
  endtask

  task automatic test_count_lowered();
    write_reg(REG_PEAK, 24'd65536);
    write_reg(REG_WAIST, 20'd3000);
    write_reg(REG_RAYLEIGH, 24'd4000);
    write_reg(REG_RSTEP, 20'd700);
    write_reg(REG_ASTEP, 20'd900);
    write_reg(REG_ORIGIN, 25'h1FFF000);
    write_reg(REG_TSAMP, 16'd8);
    write_reg(REG_RPTS, 12'd6);
    for (int i = 0; i < 29; i++) send_word(rand_sample(), i == 0);
    drain();
    write_reg(REG_TSAMP, 16'd3);
    write_reg(REG_RPTS, 12'd2);
    for (int i = 0; i < 12; i++) send_word(rand_sample(), 1'b0);
    drain();
  endtask

  task automatic test_backpressure();
    write_reg(REG_TSAMP, 16'd200);
    write_reg(REG_RPTS, 12'd2);
    send_idle_pct = 0;
    pop_stall_pct = 0;
    send_word(rand_sample(), 1'b1);
    pop_hold_left = 1500;
    for (int i = 0; i < 60; i++) send_word(rand_sample(), 1'b0);
    drain();
    for (int i = 0; i < 10; i++) send_word(rand_sample(), 1'b0);
    drain();
    for (int i = 0; i < 10; i++) send_word(rand_sample(), 1'b0);
    drain();
  endtask

  task automatic test_random_volumes(int n_words, int idle_pct, int stall_pct);
    int sent;
    int len;
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_words) begin
      load_random_beam();
      len = $urandom_range(60, 4);
      for (int i = 0; i < len; i++) begin
        send_word(rand_sample(), (i == 0) || ($urandom_range(49) == 0));
        sent++;
      end
      drain();
    end
  endtask

  initial begin
    beam_cfg.peak = 24'd65536;
    beam_cfg.waist = 20'd1000;
    beam_cfg.rayleigh = 24'd5000;
    beam_cfg.rstep = 20'd1000;
    beam_cfg.astep = 20'd1000;
    beam_cfg.origin = 25'sd0;
    beam_cfg.tsamp = 16'd1024;
    beam_cfg.rpts = 12'd64;
    time_idx = '0;
    radial_idx = '0;
    axial_idx = '0;
    pair_weight = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_count_lowered();
    test_backpressure();
    test_random_volumes(400, 0, 0);
    test_random_volumes(400, 49, 0);
    test_random_volumes(400, 0, 49);
    test_random_volumes(400, 38, 38);
    drain();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("gaussian_beam_volume_weighting test passed");
    end else begin
      $display("gaussian_beam_volume_weighting test failed");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("gaussian_beam_volume_weighting test failed");
    $finish;
  end

endmodule
